// ===== rtl/core/clause_warning_message_update_unit_assert.svh =====
// ----------------------------------------------------------------------------
// clause warning message update unit - assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CLAUSE_WARNING_MESSAGE_UPDATE_UNIT_ASSERT_SVH
`define CLAUSE_WARNING_MESSAGE_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define CWMU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CWMU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/cwmu_pkg.sv =====
// ----------------------------------------------------------------------------
// cwmu_pkg
// widths and fixed-point constants of the clause warning message update unit
// ----------------------------------------------------------------------------
`default_nettype none

package cwmu_pkg;

   localparam int MAX_LITS  = 16;
   localparam int FRAC_BITS = 15;

   localparam int BIAS_W  = 16;
   localparam int IDX_W   = $clog2(MAX_LITS);
   localparam int CNT_W   = $clog2(MAX_LITS + 1);
   localparam int ZCNT_W  = 2;

   // quotient bits produced by the divider, one per step
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [BIAS_W-1:0] ONE_FX      = BIAS_W'(1) << FRAC_BITS;
   localparam logic [BIAS_W-1:0] EPS_RESET   = BIAS_W'(33);
   localparam logic [ZCNT_W-1:0] ZCNT_SAT    = ZCNT_W'(2);

endpackage

`default_nettype wire

// ===== rtl/core/clause_warning_message_update_unit.sv =====
// ----------------------------------------------------------------------------
// clause warning message update unit
// collects one clause's bias magnitudes and emits a warning message per stored literal
// ----------------------------------------------------------------------------
// Usage: send the clause's literal biases (unsigned Q1.15, one is 32768) one
// beat each, the final one flagged with req_last_literal. Loading takes one
// beat per cycle; a bias under epsilon counts as a zero factor, every other
// stored bias is folded into a running product by a 16x16 multiply in the
// accept cycle until a second zero factor is seen. After the last beat the unit
// stalls its input and emits one result per stored literal, in order. Each
// result goes through a store read, a check state, then, when the clause has
// no zero factor and the quotient does not saturate, 16 steps of a shared
// restoring divider, and an output state held while the receiver stalls.
// Only 16 literals are held; more are dropped and reported through
// rsp_overflow. Epsilon is written on the csr channel, which is always ready,
// and must only change while the unit is idle.
`default_nettype none

module clause_warning_message_update_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // literal input
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cwmu_pkg::BIAS_W-1:0]   req_bias,
   input  wire logic                          req_last_literal,
   // message output
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cwmu_pkg::BIAS_W-1:0]        rsp_message,
   output logic [cwmu_pkg::IDX_W-1:0]         rsp_literal_index,
   output logic [cwmu_pkg::BIAS_W-1:0]        rsp_clause_impact,
   output logic                               rsp_overflow,
   output logic                               rsp_last_result,
   // epsilon register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cwmu_pkg::BIAS_W-1:0]   csr_epsilon
);

   typedef enum logic [2:0] {
      ST_LOAD,   // taking literal beats
      ST_READ,   // store read in flight
      ST_CHECK,  // pick the message path for this literal
      ST_DIV,    // restoring divide, one quotient bit a cycle
      ST_SEND    // result held until taken
   } state_type;

   // --------------------------------------------------------------------
   // registers
   // --------------------------------------------------------------------
   state_type                              state_ff,  state_in;
   logic [cwmu_pkg::BIAS_W-1:0]            eps_ff;
   logic [cwmu_pkg::BIAS_W-1:0]            prod_ff,   prod_in;
   logic [cwmu_pkg::ZCNT_W-1:0]            zcnt_ff,   zcnt_in;
   logic [cwmu_pkg::CNT_W-1:0]             count_ff,  count_in;
   logic                                   ovf_ff,    ovf_in;
   logic [cwmu_pkg::IDX_W-1:0]             idx_ff,    idx_in;
   logic [cwmu_pkg::BIAS_W-1:0]            rd_bias_ff;
   logic [cwmu_pkg::BIAS_W-1:0]            rem_ff,    rem_in;
   logic [cwmu_pkg::BIAS_W-1:0]            quo_ff,    quo_in;
   logic [cwmu_pkg::STEP_W-1:0]            step_ff,   step_in;
   logic                                   rvalid_ff, rvalid_in;
   logic [cwmu_pkg::BIAS_W-1:0]            msg_ff,    msg_in;
   logic                                   rlast_ff,  rlast_in;

   logic [cwmu_pkg::BIAS_W-1:0]            store_mem [cwmu_pkg::MAX_LITS];

   // --------------------------------------------------------------------
   // load path
   // --------------------------------------------------------------------
   logic                                   req_accept;
   logic [cwmu_pkg::BIAS_W-1:0]            bias_clamped;
   logic                                   bias_zero;
   logic                                   store_full;
   logic [2*cwmu_pkg::BIAS_W-1:0]          mul_full;
   logic                                   store_write;

   // --------------------------------------------------------------------
   // emit path
   // --------------------------------------------------------------------
   logic                                   last_idx;
   logic [cwmu_pkg::BIAS_W:0]              twice_bias;
   logic [cwmu_pkg::BIAS_W:0]              trial;
   logic                                   trial_ge;
   logic                                   dbit;
   logic [cwmu_pkg::BIAS_W-1:0]            quo_next;
   logic [cwmu_pkg::BIAS_W-1:0]            impact;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign bias_clamped = (req_bias > cwmu_pkg::ONE_FX) ? cwmu_pkg::ONE_FX : req_bias;
   assign bias_zero    = (bias_clamped < eps_ff);
   assign store_full   = (count_ff == cwmu_pkg::CNT_W'(cwmu_pkg::MAX_LITS));
   assign store_write  = req_accept && !store_full;

   // running product times the new bias in Q2.30, truncated back to Q1.15 when stored
   assign mul_full = prod_ff * bias_clamped;

   // set when idx_ff points at the last stored literal
   assign last_idx = ((cwmu_pkg::CNT_W'(idx_ff) + cwmu_pkg::CNT_W'(1)) == count_ff);

   assign impact = (zcnt_ff != '0) ? '0 : prod_ff;

   // divider datapath: dividend is product << FRAC_BITS, whose only nonzero
   // bit below the starting window is product bit 0 at position FRAC_BITS
   assign twice_bias = {rd_bias_ff, 1'b0};
   assign dbit       = (step_ff == cwmu_pkg::STEP_W'(cwmu_pkg::FRAC_BITS)) ? prod_ff[0] : 1'b0;
   assign trial      = {rem_ff, dbit};
   assign trial_ge   = (trial >= {1'b0, rd_bias_ff});
   assign quo_next   = {quo_ff[cwmu_pkg::BIAS_W-2:0], trial_ge};

   // --------------------------------------------------------------------
   // sequencer
   // --------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      prod_in   = prod_ff;
      zcnt_in   = zcnt_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      rvalid_in = rvalid_ff;
      msg_in    = msg_ff;
      rlast_in  = rlast_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (store_full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + cwmu_pkg::CNT_W'(1);
                  if (bias_zero) begin
                     if (zcnt_ff != cwmu_pkg::ZCNT_SAT) begin
                        zcnt_in = zcnt_ff + cwmu_pkg::ZCNT_W'(1);
                     end
                  end else if (zcnt_ff != cwmu_pkg::ZCNT_SAT) begin
                     prod_in = mul_full[cwmu_pkg::FRAC_BITS +: cwmu_pkg::BIAS_W];
                  end
               end
               if (req_last_literal) begin
                  idx_in   = '0;
                  state_in = ST_READ;
               end
            end
         end

         ST_READ: begin
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            priority if (zcnt_ff == '0) begin
               // zero bias only reaches here with epsilon at zero
               if (rd_bias_ff == '0 || {1'b0, prod_ff} >= twice_bias) begin
                  msg_in    = cwmu_pkg::ONE_FX;
                  rlast_in  = last_idx;
                  rvalid_in = 1'b1;
                  state_in  = ST_SEND;
               end else begin
                  rem_in   = prod_ff >> 1;
                  quo_in   = '0;
                  step_in  = cwmu_pkg::STEP_W'(cwmu_pkg::DIV_STEPS - 1);
                  state_in = ST_DIV;
               end
            end else if (zcnt_ff == cwmu_pkg::ZCNT_W'(1)) begin
               msg_in    = (rd_bias_ff < eps_ff) ? prod_ff : '0;
               rlast_in  = last_idx;
               rvalid_in = 1'b1;
               state_in  = ST_SEND;
            end else begin
               msg_in    = '0;
               rlast_in  = last_idx;
               rvalid_in = 1'b1;
               state_in  = ST_SEND;
            end
         end

         ST_DIV: begin
            rem_in  = trial_ge ? cwmu_pkg::BIAS_W'(trial - {1'b0, rd_bias_ff})
                               : trial[cwmu_pkg::BIAS_W-1:0];
            quo_in  = quo_next;
            step_in = step_ff - cwmu_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               msg_in    = (quo_next > cwmu_pkg::ONE_FX) ? cwmu_pkg::ONE_FX : quo_next;
               rlast_in  = last_idx;
               rvalid_in = 1'b1;
               state_in  = ST_SEND;
            end
         end

         ST_SEND: begin
            if (!rsp_stall) begin
               rvalid_in = 1'b0;
               if (rlast_ff) begin
                  // clause done, start a fresh one
                  prod_in  = cwmu_pkg::ONE_FX;
                  zcnt_in  = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + cwmu_pkg::IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         eps_ff    <= cwmu_pkg::EPS_RESET;
         prod_ff   <= cwmu_pkg::ONE_FX;
         zcnt_ff   <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         idx_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prod_ff   <= prod_in;
         zcnt_ff   <= zcnt_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         idx_ff    <= idx_in;
         rvalid_ff <= rvalid_in;
         if (csr_valid && csr_ready) begin
            eps_ff <= csr_epsilon;
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      msg_ff   <= msg_in;
      rlast_ff <= rlast_in;
   end

   // literal store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_write) begin
         store_mem[count_ff[cwmu_pkg::IDX_W-1:0]] <= bias_clamped;
      end
      rd_bias_ff <= store_mem[idx_ff];
   end

   // --------------------------------------------------------------------
   // outputs
   // --------------------------------------------------------------------
   assign rsp_valid         = rvalid_ff;
   assign rsp_message       = msg_ff;
   assign rsp_literal_index = idx_ff;
   assign rsp_clause_impact = impact;
   assign rsp_overflow      = ovf_ff;
   assign rsp_last_result   = rlast_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cwmu_checker.sv =====
// ----------------------------------------------------------------------------
// cwmu_checker
// port-level checks of the clause warning message update unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "clause_warning_message_update_unit_assert.svh"

module cwmu_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [cwmu_pkg::BIAS_W-1:0]   rsp_message,
   input wire logic [cwmu_pkg::IDX_W-1:0]    rsp_literal_index,
   input wire logic [cwmu_pkg::BIAS_W-1:0]   rsp_clause_impact,
   input wire logic                          rsp_last_result
);

   // a held result beat keeps its payload
   `CWMU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_message) && $stable(rsp_literal_index) && $stable(rsp_last_result), "result beat changed while stalled")

   // no input beat is taken while results are pending
   `CWMU_ASSERT_NOW(a_busy_stall, clock, reset, rsp_valid, req_stall, "input open during emission")

   // messages never exceed one
   `CWMU_ASSERT_NOW(a_msg_range, clock, reset, rsp_valid, rsp_message <= cwmu_pkg::ONE_FX, "message above one")

   // a nonzero impact means no zero factor, so every message is nonzero
   `CWMU_ASSERT_NOW(a_msg_nonzero, clock, reset, rsp_valid && (rsp_clause_impact != '0), rsp_message != '0, "zero message with nonzero impact")

   // following results need a store read first
   `CWMU_ASSERT_NEXT(a_gap, clock, reset, rsp_valid && !rsp_stall && !rsp_last_result, !rsp_valid, "back-to-back result beats")

endmodule

bind clause_warning_message_update_unit cwmu_checker u_cwmu_checker (.*);

`default_nettype wire

// ===== dv/clause_warning_message_update_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clause_warning_message_update_unit_tb
// self-checking bench: literal biases go in through a queued driver, a
// scoreboard predicts each clause's warning beats and a monitor compares them
// field by field, over several epsilon settings and handshake idling mixes
// ----------------------------------------------------------------------------

module clause_warning_message_update_unit_tb;

   // unit widths and constants
   localparam int                 BIAS_W    = cwmu_pkg::BIAS_W;
   localparam int                 IDX_W     = cwmu_pkg::IDX_W;
   localparam int                 MAX_LITS  = cwmu_pkg::MAX_LITS;
   localparam int                 FRAC_BITS = cwmu_pkg::FRAC_BITS;
   localparam logic [BIAS_W-1:0]  ONE_FX    = cwmu_pkg::ONE_FX;
   localparam logic [BIAS_W-1:0]  EPS_RESET = cwmu_pkg::EPS_RESET;
   localparam logic [1:0]         ZCNT_SAT  = cwmu_pkg::ZCNT_SAT;

   // one literal beat waiting to be driven
   typedef struct packed {
      logic [BIAS_W-1:0] bias;
      logic              is_last;
   } lit_beat_type;

   // one warning beat as it should leave the unit
   typedef struct packed {
      logic [BIAS_W-1:0] message;
      logic [IDX_W-1:0]  index;
      logic [BIAS_W-1:0] impact;
      logic              overflow;
      logic              is_last;
   } warn_beat_type;

   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int QUIET_LIMIT  = 4000;  // cycles with work outstanding but no beat
   localparam int SETTLE_WAIT  = 24;    // idle cycles after the last warning beat

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // every block input starts at a known value
   logic              req_valid        = 1'b0;
   logic [BIAS_W-1:0] req_bias         = '0;
   logic              req_last_literal = 1'b0;
   logic              rsp_stall        = 1'b0;
   logic              csr_valid        = 1'b0;
   logic [BIAS_W-1:0] csr_epsilon      = EPS_RESET;

   logic              req_stall;
   logic              rsp_valid;
   logic [BIAS_W-1:0] rsp_message;
   logic [IDX_W-1:0]  rsp_literal_index;
   logic [BIAS_W-1:0] rsp_clause_impact;
   logic              rsp_overflow;
   logic              rsp_last_result;
   logic              csr_ready;

   clause_warning_message_update_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_bias          (req_bias),
      .req_last_literal  (req_last_literal),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_message       (rsp_message),
      .rsp_literal_index (rsp_literal_index),
      .rsp_clause_impact (rsp_clause_impact),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_result   (rsp_last_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_epsilon       (csr_epsilon)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // bookkeeping shared by the processes
   // ------------------------------------------------------------------
   lit_beat_type  lit_pending[$];     // literals not yet on the bus
   warn_beat_type warn_expected[$];   // predicted warning beats, oldest first
   int unsigned lits_queued   = 0;
   int unsigned lits_taken    = 0;
   int unsigned warns_checked = 0;
   int unsigned errors        = 0;
   int unsigned send_idle_pct = 0;  // chance the sender skips a cycle
   int unsigned stall_pct     = 0;  // chance the receiver stalls a cycle
   int unsigned hold_req      = 0;  // bumped to ask for a long hold-off
   int unsigned hold_ack      = 0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned eps_writes    = 0;

   // clause coverage tallies for the summary
   int unsigned clauses_clean = 0;
   int unsigned clauses_one   = 0;
   int unsigned clauses_two   = 0;
   int unsigned clauses_ovf   = 0;

   // ------------------------------------------------------------------
   // clause scoreboard state, mirrors the unit
   // ------------------------------------------------------------------
   logic [BIAS_W-1:0] eps_now = EPS_RESET;
   logic [BIAS_W-1:0] stored_bias[MAX_LITS];
   logic [BIAS_W-1:0] prod     = ONE_FX;
   logic [1:0]        zero_cnt = '0;
   int unsigned       lit_count = 0;
   logic              clause_ovf = 1'b0;

   // warning for one stored literal given the clause totals
   function automatic logic [BIAS_W-1:0] warning_for(logic [BIAS_W-1:0] b);
      logic [31:0] quot;
      if (zero_cnt == 0) begin
         // zero bias with no zero factor only happens at epsilon 0, divide saturates
         if (b == 0)
            return ONE_FX;
         quot = (32'(prod) << FRAC_BITS) / 32'(b);
         return (quot > 32'(ONE_FX)) ? ONE_FX : quot[BIAS_W-1:0];
      end
      // exactly one zero: only the zero literal sees the product
      if (zero_cnt == 1 && b < eps_now)
         return prod;
      return '0;
   endfunction

   // fold one accepted literal in; on the last one queue the clause's warnings
   task automatic fold_literal(input logic [BIAS_W-1:0] bias_in, input logic is_last);
      logic [BIAS_W-1:0] b;
      logic [31:0]       wide;
      warn_beat_type     w;
      b = (bias_in > ONE_FX) ? ONE_FX : bias_in;   // clamp above one
      if (lit_count < MAX_LITS) begin
         stored_bias[lit_count] = b;
         lit_count++;
         if (b < eps_now) begin
            if (zero_cnt < ZCNT_SAT)
               zero_cnt++;
         end else if (zero_cnt < ZCNT_SAT) begin
            wide = 32'(prod) * 32'(b);
            prod = wide[FRAC_BITS +: BIAS_W];
         end
      end else begin
         // store full: beat dropped, only the flag remembers it
         clause_ovf = 1'b1;
      end
      if (is_last) begin
         for (int k = 0; k < lit_count; k++) begin
            w.message  = warning_for(stored_bias[k]);
            w.index    = IDX_W'(k);
            w.impact   = (zero_cnt != 0) ? '0 : prod;
            w.overflow = clause_ovf;
            w.is_last  = (k + 1 == lit_count);
            warn_expected.push_back(w);
         end
         case (zero_cnt)
            2'd0:    clauses_clean++;
            2'd1:    clauses_one++;
            default: clauses_two++;
         endcase
         if (clause_ovf)
            clauses_ovf++;
         prod       = ONE_FX;
         zero_cnt   = '0;
         lit_count  = 0;
         clause_ovf = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // literal driver: feeds the req channel from lit_pending
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      lit_beat_type nxt;
      bit           offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // beat taken at this edge goes to the scoreboard
         if (req_valid && !req_stall) begin
            fold_literal(req_bias, req_last_literal);
            lits_taken++;
         end
         // payload only moves once the current beat is gone
         if (!req_valid || !req_stall) begin
            offer = (lit_pending.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (offer) begin
               nxt = lit_pending.pop_front();
               req_bias         <= nxt.bias;
               req_last_literal <= nxt.is_last;
            end
            req_valid <= offer;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver stall: random per phase, plus a counted long hold-off
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack  = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // warning monitor: compare each beat with the oldest prediction
   // ------------------------------------------------------------------
   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch on warning beat %0d: expected %0d, got %0d",
                  $time, what, warns_checked, want, got);
      end
   endfunction

   always @(posedge clock) begin
      warn_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (warn_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected warning beat: expected none, got msg %0d idx %0d",
                     $time, rsp_message, rsp_literal_index);
         end else begin
            want = warn_expected.pop_front();
            check_field("message",       want.message,  rsp_message);
            check_field("literal_index", want.index,    rsp_literal_index);
            check_field("clause_impact", want.impact,   rsp_clause_impact);
            check_field("overflow",      want.overflow, rsp_overflow);
            check_field("last_result",   want.is_last,  rsp_last_result);
         end
         warns_checked++;
      end
   end

   // ------------------------------------------------------------------
   // watchdog: work outstanding but no beat moving on any channel
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      bit busy;
      bit moved;
      busy  = (lits_taken != lits_queued) || (warn_expected.size() != 0) || csr_valid;
      moved = (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
              || (csr_valid && csr_ready);
      if (reset || !busy || moved)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles, %0d warnings outstanding",
                  $time, quiet_cycles, warn_expected.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_lit(input logic [BIAS_W-1:0] bias, input logic is_last);
      lit_beat_type t;
      t.bias    = bias;
      t.is_last = is_last;
      lit_pending.push_back(t);
      lits_queued++;
   endtask

   // bias mix around the current epsilon: zeros, threshold edge, above one
   function automatic logic [BIAS_W-1:0] pick_bias();
      int unsigned c;
      int unsigned e;
      c = $urandom_range(99);
      e = eps_now;
      if (c < 12)
         return BIAS_W'($urandom_range(e - 1, 0));
      if (c < 20)
         return BIAS_W'(e - 1 + $urandom_range(1));
      if (c < 28)
         return BIAS_W'($urandom_range(65535, 32769));
      if (c < 34)
         return ONE_FX;
      return BIAS_W'($urandom_range(32768, e));
   endfunction

   // mostly short clauses, some up to the store depth, a few past it
   task automatic queue_clause();
      int unsigned sel;
      int unsigned len;
      sel = $urandom_range(99);
      if (sel < 60)
         len = $urandom_range(5, 1);
      else if (sel < 88)
         len = $urandom_range(MAX_LITS, 6);
      else
         len = $urandom_range(MAX_LITS + 4, MAX_LITS + 1);
      for (int i = 0; i < len; i++)
         push_lit(pick_bias(), i == len - 1);
   endtask

   // wait until every literal is in and every warning is out, then let it settle
   task automatic drain();
      do
         @(posedge clock);
      while (lits_taken != lits_queued || warn_expected.size() != 0);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // epsilon write, only called with the unit idle
   task automatic write_epsilon(input logic [BIAS_W-1:0] value);
      csr_valid   <= 1'b1;
      csr_epsilon <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      eps_now = value;
      eps_writes++;
      @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned send_pct, input int unsigned st_pct,
                               input logic [BIAS_W-1:0] eps, input int unsigned n_lits,
                               input bit with_hold);
      int unsigned start;
      write_epsilon(eps);
      send_idle_pct = send_pct;
      stall_pct     = st_pct;
      if (with_hold)
         hold_req++;   // receiver holds off while the sender keeps offering
      start = lits_queued;
      while (lits_queued - start < n_lits)
         queue_clause();
      drain();
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset epsilon, no idling
      // two full-scale biases, each divide gives exactly one
      push_lit(ONE_FX, 1'b0);
      push_lit(ONE_FX, 1'b1);
      // lone zero literal gets the untouched product
      push_lit(16'd0, 1'b1);
      // all-ones bias clamps to one, then a half and a zero
      push_lit(16'hFFFF, 1'b0);
      push_lit(16'd16384, 1'b0);
      push_lit(16'd1, 1'b1);
      // two zeros, every message is 0
      push_lit(16'd0, 1'b0);
      push_lit(16'd32, 1'b1);
      // store full: threshold edge pair, fill to depth, last beat dropped
      push_lit(16'd32, 1'b0);
      push_lit(16'd33, 1'b0);
      for (int i = 0; i < MAX_LITS - 2; i++)
         push_lit(BIAS_W'($urandom_range(32768, 30000)), 1'b0);
      push_lit(16'd0, 1'b1);
      drain();

      // random part: epsilon extremes and idling mixes
      random_phase(0,  0,  16'd1,                             80, 1'b0);
      random_phase(65, 0,  ONE_FX,                            60, 1'b0);
      random_phase(0,  65, BIAS_W'($urandom_range(600, 1)),   80, 1'b1);
      random_phase(36, 36, BIAS_W'($urandom_range(32768, 1)), 80, 1'b0);
      random_phase(0,  0,  BIAS_W'($urandom_range(4000, 1)),  80, 1'b0);

      // anything still predicted never showed up
      if (warn_expected.size() != 0) begin
         errors += warn_expected.size();
         $display("%0t: %0d warning beats never arrived: expected %0d, got 0",
                  $time, warn_expected.size(), warn_expected.size());
      end

      $display("covered %0d literal beats, %0d warning beats, %0d epsilon writes",
               lits_taken, warns_checked, eps_writes);
      $display("clauses: %0d with no zero, %0d with one, %0d with two, %0d overflowed",
               clauses_clean, clauses_one, clauses_two, clauses_ovf);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
